// ----- design/ultrasonic_echo_ranger_unit_defines.svh -----
// Assertion helpers shared by the ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/uer_pkg.sv -----
`default_nettype none

package uer_pkg;

    // Fixed field widths.
    localparam int DIST_W     = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 40;

    // Default counter width for the tick and echo width counters.
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  PRE_LOW_RST = 8'd40;
    localparam logic [7:0]  PULSE_RST   = 8'd10;
    localparam logic [15:0] TIMEOUT_RST = 16'hFF00;
    localparam logic [15:0] SCALE_RST   = 16'd1114;
    localparam logic [8:0]  WEIGHT_RST  = 9'd128;

    // Full weight, Q1.8 value of 1.0.
    localparam logic [8:0] WEIGHT_ONE = 9'd256;

    typedef struct packed {
        logic [7:0]  pre_low_ticks;
        logic [7:0]  pulse_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] scale_per_tick;
        logic [8:0]  smooth_weight;
    } t_cfg;

    // Ranging cycle phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRELOW,
        PH_PULSE,
        PH_WAITRISE,
        PH_MEASURE
    } t_phase;

    // Blend sequencer states.
    typedef enum logic [2:0] {
        BL_IDLE,
        BL_SCALE,
        BL_ROUND,
        BL_NEW,
        BL_OLD,
        BL_SUM
    } t_blend_state;

    // Outcome of one tick, from the phase machine to the top.
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic tout;
        logic blend_req;
    } t_tick_res;

    // Status of the blend unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_blend_stat;

endpackage

`default_nettype wire

// ----- design/uer_tick.sv -----
`default_nettype none

module uer_tick
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_start,
    input  wire logic                  i_echo,
    input  wire t_cfg                  i_cfg,
    output t_tick_res                  o_res,
    output logic [COUNT_BITS-1:0]      o_width
);

    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    t_phase                r_phase, n_phase, ph_eff;
    logic [COUNT_BITS-1:0] r_pt, n_pt, pt_eff;
    logic [COUNT_BITS-1:0] r_ew, n_ew;
    logic [COUNT_BITS-1:0] lim, pt_inc;
    logic [LIM_W-1:0]      tmo_x, max_x;
    logic [7:0]            plen;
    logic                  pre_done, plen_one, pulse_end, lim_zero, rise_tmo, width_tmo;

    // Timeout limited to what the counters can hold.
    assign tmo_x    = LIM_W'(i_cfg.timeout_ticks);
    assign max_x    = LIM_W'({COUNT_BITS{1'b1}});
    assign lim      = (tmo_x > max_x) ? COUNT_BITS'(max_x) : COUNT_BITS'(tmo_x);
    assign lim_zero = (lim == '0);

    // A start item in idle acts as the first pre-low tick.
    assign ph_eff = (r_phase == PH_IDLE && i_start) ? PH_PRELOW : r_phase;
    assign pt_eff = (r_phase == PH_IDLE && i_start) ? '0 : r_pt;

    // Phase compares; a zero pulse length counts as one tick.
    assign plen      = (i_cfg.pulse_ticks == 8'd0) ? 8'd1 : i_cfg.pulse_ticks;
    assign plen_one  = (plen == 8'd1);
    assign pre_done  = (pt_eff >= COUNT_BITS'(i_cfg.pre_low_ticks));
    assign pt_inc    = r_pt + COUNT_BITS'(1);
    assign pulse_end = (pt_inc >= COUNT_BITS'(plen));
    assign rise_tmo  = (r_pt >= lim);
    assign width_tmo = (r_ew >= lim);

    // Next phase and counters for this tick.
    always_comb begin
        n_phase = r_phase;
        n_pt    = r_pt;
        n_ew    = r_ew;
        unique case (ph_eff)
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            PH_PRELOW: begin
                if (pre_done) begin
                    if (plen_one) begin
                        n_phase = PH_WAITRISE;
                        n_pt    = '0;
                    end else begin
                        n_phase = PH_PULSE;
                        n_pt    = COUNT_BITS'(1);
                    end
                end else begin
                    n_phase = PH_PRELOW;
                    n_pt    = pt_eff + COUNT_BITS'(1);
                end
            end
            PH_PULSE: begin
                if (pulse_end) begin
                    n_phase = PH_WAITRISE;
                    n_pt    = '0;
                end else begin
                    n_pt = pt_inc;
                end
            end
            PH_WAITRISE: begin
                if (i_echo) begin
                    // The rising sample is the first high sample of the width.
                    if (lim_zero) begin
                        n_phase = PH_IDLE;
                        n_ew    = '0;
                    end else begin
                        n_phase = PH_MEASURE;
                        n_ew    = COUNT_BITS'(1);
                    end
                end else if (rise_tmo) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_pt = pt_inc;
                end
            end
            PH_MEASURE: begin
                if (!i_echo || width_tmo) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_ew = r_ew + COUNT_BITS'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Per-tick outputs.
    always_comb begin
        o_res      = '0;
        o_res.busy = (n_phase != PH_IDLE);
        unique case (ph_eff)
            PH_IDLE: begin
                o_res.trig = 1'b0;
            end
            PH_PRELOW: begin
                o_res.trig = pre_done;
            end
            PH_PULSE: begin
                o_res.trig = 1'b1;
            end
            PH_WAITRISE: begin
                o_res.done = (i_echo && lim_zero) || (!i_echo && rise_tmo);
                o_res.tout = o_res.done;
            end
            PH_MEASURE: begin
                o_res.done      = !i_echo || width_tmo;
                o_res.tout      = i_echo && width_tmo;
                o_res.blend_req = !i_echo;
            end
            default: begin
                o_res.trig = 1'b0;
            end
        endcase
    end

    assign o_width = r_ew;

    // Phase state, advanced once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pt    <= '0;
            r_ew    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pt    <= n_pt;
            r_ew    <= n_ew;
        end
    end

endmodule

`default_nettype wire

// ----- design/uer_blend.sv -----
`default_nettype none

module uer_blend
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COUNT_BITS-1:0] i_width,
    input  wire t_cfg                  i_cfg,
    output t_blend_stat                o_stat,
    output logic [DIST_W-1:0]          o_smoothed
);

    t_blend_state          r_state, n_state;
    logic [COUNT_BITS-1:0] r_width;
    logic [DIST_W-1:0]     r_nv, r_smoothed, nv, n_smoothed;
    logic [PROD_W-1:0]     r_prod, mult_p;
    logic [32:0]           r_acc;
    logic [DIST_W-1:0]     mult_a;
    logic [15:0]           mult_b;
    logic [8:0]            w_clip, w_inv;
    logic [PROD_W:0]       rnd;
    logic [33:0]           sum;
    logic                  r_done;

    // Weight clipped to 1.0 and its complement.
    assign w_clip = (i_cfg.smooth_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.smooth_weight;
    assign w_inv  = WEIGHT_ONE - w_clip;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BL_IDLE:  if (i_start) n_state = BL_SCALE;
            BL_SCALE: n_state = BL_ROUND;
            BL_ROUND: n_state = BL_NEW;
            BL_NEW:   n_state = BL_OLD;
            BL_OLD:   n_state = BL_SUM;
            BL_SUM:   n_state = BL_IDLE;
            default:  n_state = BL_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            BL_SCALE: begin
                mult_a = DIST_W'(r_width);
                mult_b = i_cfg.scale_per_tick;
            end
            BL_NEW: begin
                mult_a = r_nv;
                mult_b = 16'(w_inv);
            end
            BL_OLD: begin
                mult_a = r_smoothed;
                mult_b = 16'(w_clip);
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign mult_p = {{(PROD_W-DIST_W){1'b0}}, mult_a} * {{(PROD_W-16){1'b0}}, mult_b};

    // New distance: scaled width rounded to 1/256 cm and saturated.
    assign rnd = (PROD_W+1)'(r_prod) + (PROD_W+1)'(128);
    assign nv  = (|rnd[PROD_W:DIST_W+8]) ? DIST_MAX : rnd[DIST_W+7:8];

    // Weighted sum of the new and old distance, rounded.
    assign sum        = 34'(r_acc) + 34'(r_prod[32:0]) + 34'd128;
    assign n_smoothed = (|sum[33:DIST_W+8]) ? DIST_MAX : sum[DIST_W+7:8];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BL_IDLE;
            r_done     <= 1'b0;
            r_smoothed <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == BL_SUM);
            if (r_state == BL_SUM) begin
                r_smoothed <= n_smoothed;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == BL_IDLE && i_start) begin
            r_width <= i_width;
        end
        if (r_state == BL_SCALE || r_state == BL_NEW || r_state == BL_OLD) begin
            r_prod <= mult_p;
        end
        if (r_state == BL_ROUND) begin
            r_nv <= nv;
        end
        if (r_state == BL_OLD) begin
            r_acc <= r_prod[32:0];
        end
    end

    assign o_stat.busy = (r_state != BL_IDLE);
    assign o_stat.done = r_done;
    assign o_smoothed  = r_smoothed;

endmodule

`default_nettype wire

// ----- design/ultrasonic_echo_ranger_unit.sv -----
`default_nettype none
`include "ultrasonic_echo_ranger_unit_defines.svh"

// Ultrasonic echo ranger. Each input word is one 1 us tick; a word with
// tuser set in idle starts a ranging cycle (trigger low, trigger pulse, echo
// rise wait, echo width count), and every word returns one output word with
// the trigger level to drive for that tick. A plain tick's word is in the
// output register the cycle after it is accepted, and the next word is taken
// then if the output slot is free or being drained. The tick on which the echo
// falls runs the distance scaling and blending through one shared 24x16
// multiplier under a small sequencer, five steps plus a hand-off; that word
// follows the hand-off and no word is taken meanwhile. Configuration writes are
// applied at once and must be made while no measurement is in flight.
module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,  // [0] echo_level, [7:1] zero
    input  wire logic                  i_s_tuser,  // [0] mode
    // Output stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [3] timed_out,
    // [27:4] distance, [31:28] zero
    output logic [31:0]                o_m_tdata,
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    t_tick_res             tick_res;
    t_blend_stat           blend_stat;
    logic [COUNT_BITS-1:0] echo_width;
    logic [DIST_W-1:0]     smoothed;
    logic                  s_acc, m_acc, blend_go;
    logic                  r_out_valid, r_pend;
    logic                  r_out_trig, r_out_busy, r_out_done, r_out_tout;
    logic [DIST_W-1:0]     r_out_dist;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_low_ticks  <= PRE_LOW_RST;
            r_cfg.pulse_ticks    <= PULSE_RST;
            r_cfg.timeout_ticks  <= TIMEOUT_RST;
            r_cfg.scale_per_tick <= SCALE_RST;
            r_cfg.smooth_weight  <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRE_LOW: r_cfg.pre_low_ticks  <= i_cfg_data[7:0];
                CFG_PULSE:   r_cfg.pulse_ticks    <= i_cfg_data[7:0];
                CFG_TIMEOUT: r_cfg.timeout_ticks  <= i_cfg_data[15:0];
                CFG_SCALE:   r_cfg.scale_per_tick <= i_cfg_data[15:0];
                CFG_WEIGHT:  r_cfg.smooth_weight  <= i_cfg_data[8:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    // Handshakes: one word in flight, output slot must be free or draining.
    assign o_s_tready = !r_pend && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign blend_go   = s_acc && tick_res.blend_req;

    uer_tick #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s_acc),
        .i_start (i_s_tuser),
        .i_echo  (i_s_tdata[0]),
        .i_cfg   (r_cfg),
        .o_res   (tick_res),
        .o_width (echo_width)
    );

    uer_blend #(
        .COUNT_BITS (COUNT_BITS)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (blend_go),
        .i_width    (echo_width),
        .i_cfg      (r_cfg),
        .o_stat     (blend_stat),
        .o_smoothed (smoothed)
    );

    // Output word valid and pending blend tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (blend_go) begin
            r_pend      <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (blend_stat.done) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_trig <= tick_res.trig;
            r_out_busy <= tick_res.busy;
            r_out_done <= tick_res.done;
            r_out_tout <= tick_res.tout;
            r_out_dist <= smoothed;
        end else if (blend_stat.done) begin
            r_out_dist <= smoothed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_dist, r_out_tout, r_out_done, r_out_busy, r_out_trig};

    `UER_ASSERT_NEXT(a_blend_sets_pend, i_clk, i_rst_n, blend_go, r_pend && !r_out_valid,
        "echo fall tick did not hold the output for the blend")
    `UER_ASSERT_NEXT(a_plain_tick_out, i_clk, i_rst_n, s_acc && !tick_res.blend_req,
        r_out_valid, "plain tick did not load the output word")
    `UER_ASSERT_NOW(a_pend_no_out, i_clk, i_rst_n, r_pend, !r_out_valid,
        "output word valid while a blend is pending")
    `UER_ASSERT_NOW(a_blend_in_pend, i_clk, i_rst_n, blend_stat.busy || blend_stat.done,
        r_pend, "blend unit active without a pending word")

endmodule

`default_nettype wire

// ----- bench/tb_ultrasonic_echo_ranger_unit.sv -----
module tb_ultrasonic_echo_ranger_unit;
    import uer_pkg::*;

    // Meaning of the tuser bit on the input stream.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Most mismatch lines printed; later ones are only counted.
    localparam int PRINT_CAP = 40;
    localparam int RUN_LIMIT = 20_000_000;

    typedef struct packed {
        logic mode;
        logic echo;
    } tick_item_t;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic              tout;
        logic [DIST_W-1:0] distance;
    } ranging_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = '0;   // [0] echo_level, [7:1] zero
    logic                  i_s_tuser = 1'b0; // [0] mode
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [0] trigger_level, [1] busy_res, [2] done_res, [3] timed_out,
    // [27:4] distance, [31:28] zero
    logic [31:0]           o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ultrasonic_echo_ranger_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Ranger copy: settings and cycle state as the block should hold them.
    logic [7:0]        cfg_pre_low = PRE_LOW_RST;
    logic [7:0]        cfg_pulse   = PULSE_RST;
    logic [15:0]       cfg_timeout = TIMEOUT_RST;
    logic [15:0]       cfg_scale   = SCALE_RST;
    logic [8:0]        cfg_weight  = WEIGHT_RST;
    t_phase            rng_phase   = PH_IDLE;
    logic [15:0]       rng_ticks   = '0;
    logic [15:0]       rng_width   = '0;
    logic [DIST_W-1:0] rng_dist    = '0;

    // Settings as the stimulus side last wrote them, for sequence lengths.
    int gen_pre = 40;
    int gen_plen = 10;
    int gen_timeout = 65280;

    tick_item_t    tick_q[$];
    ranging_word_t ranger_words_q[$];
    int            queued_cnt = 0;
    int            got_cnt = 0;
    int            err_cnt = 0;

    // Handshake state shared between the sampling and driving blocks.
    logic       s_took = 1'b0;
    logic       m_took = 1'b0;
    logic       drv_hold = 1'b0;
    logic       drv_calm = 1'b0;
    int         drv_gap = 0;
    tick_item_t drv_item;
    logic       rcv_calm = 1'b0;
    int         rcv_stall = 0;

    // Scale a width to 1/256 cm and blend it with the stored distance.
    function automatic logic [DIST_W-1:0] blend_distance(logic [15:0] width);
        logic [63:0] fresh;
        logic [63:0] wt;
        logic [63:0] sum;
        fresh = (64'(width) * 64'(cfg_scale) + 64'd128) >> 8;
        if (fresh > 64'(DIST_MAX)) fresh = 64'(DIST_MAX);
        wt = (cfg_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(cfg_weight);
        sum = (fresh * (64'd256 - wt) + 64'(rng_dist) * wt + 64'd128) >> 8;
        if (sum > 64'(DIST_MAX)) sum = 64'(DIST_MAX);
        return sum[DIST_W-1:0];
    endfunction

    // Advance the ranging cycle by one tick and return the word it produces.
    function automatic ranging_word_t ranger_tick(logic start, logic echo);
        ranging_word_t res;
        logic [15:0]   plen;
        res = '0;
        plen = (cfg_pulse == 8'd0) ? 16'd1 : {8'd0, cfg_pulse};
        if (rng_phase == PH_IDLE && start) begin
            rng_phase = PH_PRELOW;
            rng_ticks = '0;
        end
        if (rng_phase == PH_PRELOW) begin
            if (rng_ticks >= {8'd0, cfg_pre_low}) begin
                rng_phase = PH_PULSE;
                rng_ticks = '0;
            end else begin
                rng_ticks = rng_ticks + 16'd1;
            end
        end
        case (rng_phase)
            PH_PULSE: begin
                res.trig = 1'b1;
                rng_ticks = rng_ticks + 16'd1;
                if (rng_ticks >= plen) begin
                    rng_phase = PH_WAITRISE;
                    rng_ticks = '0;
                end
            end
            PH_WAITRISE: begin
                if (echo) begin
                    rng_phase = PH_MEASURE;
                    rng_width = '0;
                end else if (rng_ticks >= cfg_timeout) begin
                    res.done = 1'b1;
                    res.tout = 1'b1;
                    rng_phase = PH_IDLE;
                end else begin
                    rng_ticks = rng_ticks + 16'd1;
                end
            end
            PH_MEASURE: begin
                if (!echo) begin
                    rng_dist = blend_distance(rng_width);
                    res.done = 1'b1;
                    rng_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
        // The echo width counts in the same tick, the rising sample included.
        if (rng_phase == PH_MEASURE && !res.done && echo) begin
            if (rng_width >= cfg_timeout) begin
                res.done = 1'b1;
                res.tout = 1'b1;
                rng_phase = PH_IDLE;
            end else begin
                rng_width = rng_width + 16'd1;
            end
        end
        res.busy = (rng_phase != PH_IDLE);
        res.distance = rng_dist;
        return res;
    endfunction

    function automatic void ranger_cfg_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PRE_LOW: cfg_pre_low = val[7:0];
            CFG_PULSE:   cfg_pulse = val[7:0];
            CFG_TIMEOUT: cfg_timeout = val;
            CFG_SCALE:   cfg_scale = val;
            CFG_WEIGHT:  cfg_weight = val[8:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("mismatch on %0s at word %0d: got %0h, want %0h",
                     what, got_cnt, got, want);
    endtask

    // Sample both streams and the write port at the rising edge.
    always @(posedge i_clk) begin
        ranging_word_t want;
        s_took <= i_rst_n && i_s_tvalid && o_s_tready;
        m_took <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_cfg_we) ranger_cfg_write(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready)
                ranger_words_q.push_back(ranger_tick(i_s_tuser, i_s_tdata[0]));
            if (o_m_tvalid && i_m_tready) begin
                got_cnt++;
                if (ranger_words_q.size() == 0) begin
                    report_mismatch("unexpected word", o_m_tdata, 32'd0);
                end else begin
                    want = ranger_words_q.pop_front();
                    if (o_m_tdata[0] !== want.trig)
                        report_mismatch("trigger_level", 32'(o_m_tdata[0]), 32'(want.trig));
                    if (o_m_tdata[1] !== want.busy)
                        report_mismatch("busy_res", 32'(o_m_tdata[1]), 32'(want.busy));
                    if (o_m_tdata[2] !== want.done)
                        report_mismatch("done_res", 32'(o_m_tdata[2]), 32'(want.done));
                    if (o_m_tdata[3] !== want.tout)
                        report_mismatch("timed_out", 32'(o_m_tdata[3]), 32'(want.tout));
                    if (o_m_tdata[27:4] !== want.distance)
                        report_mismatch("distance", 32'(o_m_tdata[27:4]),
                                        32'(want.distance));
                    if (o_m_tdata[31:28] !== 4'd0)
                        report_mismatch("padding", 32'(o_m_tdata[31:28]), 32'd0);
                end
            end
        end
    end

    // Input driver: present pending ticks with a random gap before each word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (drv_hold && s_took) begin
                drv_hold = 1'b0;
                if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
                drv_gap = drv_calm ? 0 : $urandom_range(0, 9);
            end
            if (!drv_hold) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (tick_q.size() != 0) begin
                    drv_item = tick_q.pop_front();
                    i_s_tuser <= drv_item.mode;
                    i_s_tdata <= {7'd0, drv_item.echo};
                    drv_hold = 1'b1;
                end
            end
            i_s_tvalid <= drv_hold;
        end
    end

    // Output side: hold off tready for a random stall after each word.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (m_took) begin
                if ($urandom_range(0, 49) == 0) rcv_calm = !rcv_calm;
                rcv_stall = rcv_calm ? 0 : $urandom_range(0, 9);
            end else if (rcv_stall > 0) begin
                rcv_stall--;
            end
            i_m_tready <= (rcv_stall == 0);
        end
    end

    task automatic put_tick(logic mode, logic echo);
        tick_q.push_back('{mode: mode, echo: echo});
        queued_cnt++;
    endtask

    // A start request now and then while a cycle runs; the block ignores it.
    function automatic logic busy_mode();
        return ($urandom_range(0, 7) == 0) ? MODE_START : MODE_TICK;
    endfunction

    // One ranging cycle: start, pre-low and trigger ticks, low echo ticks, high
    // echo ticks and, if asked, the falling tick that ends the measurement.
    task automatic put_ranging(int lows, int highs, bit fall);
        put_tick(MODE_START, 1'($urandom_range(0, 1)));
        repeat (gen_pre + gen_plen - 1) put_tick(busy_mode(), 1'($urandom_range(0, 1)));
        repeat (lows) put_tick(busy_mode(), 1'b0);
        repeat (highs) put_tick(busy_mode(), 1'b1);
        if (fall) put_tick(busy_mode(), 1'b0);
    endtask

    // Mostly well-formed cycles; with a short limit, also lost or stuck echoes.
    task automatic put_random_ranging();
        int lim;
        int pick;
        int lows;
        int highs;
        lim = gen_timeout;
        pick = $urandom_range(0, 9);
        if (lim <= 64 && (pick == 0 || (lim == 0 && pick < 5))) begin
            put_ranging(lim + 1, 0, 1'b0);
        end else if (lim <= 64 && (pick == 1 || lim == 0)) begin
            put_ranging($urandom_range(0, lim), lim + 1, 1'b0);
        end else begin
            lows = $urandom_range(0, (lim < 30) ? lim : 30);
            highs = (pick == 9) ? $urandom_range(1, 600) : $urandom_range(1, 120);
            if (highs > lim) highs = lim;
            put_ranging(lows, highs, 1'b1);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
    endtask

    // Wait until every word is back, then rewrite all registers. Unused bits
    // of the narrow registers carry junk, and one unused index gets a write.
    task automatic load_settings(int pre, int pulse, int tmo, int scale, int wt);
        while (got_cnt < queued_cnt) @(negedge i_clk);
        write_reg(CFG_PRE_LOW, {8'($urandom), 8'(pre)});
        write_reg(CFG_PULSE, {8'($urandom), 8'(pulse)});
        write_reg(CFG_TIMEOUT, 16'(tmo));
        write_reg(CFG_SCALE, 16'(scale));
        write_reg(CFG_WEIGHT, {7'($urandom), 9'(wt)});
        write_reg(CFG_WEIGHT + 3'($urandom_range(1, 3)), 16'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_pre = pre;
        gen_plen = (pulse == 0) ? 1 : pulse;
        gen_timeout = tmo;
    endtask

    task automatic run_phase(int pre, int pulse, int tmo, int scale, int wt, int budget);
        int first;
        load_settings(pre, pulse, tmo, scale, wt);
        first = queued_cnt;
        while (queued_cnt - first < budget) begin
            repeat ($urandom_range(0, 3)) put_tick(MODE_TICK, 1'($urandom_range(0, 1)));
            put_random_ranging();
        end
    endtask

    function automatic int random_weight();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
                                           : $urandom_range(0, 256);
    endfunction

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks under the reset settings.
        put_tick(MODE_TICK, 1'b0);
        put_tick(MODE_TICK, 1'b1);
        // Pulse on the start tick, one-tick pulse, zero limit for both waits.
        load_settings(0, 0, 0, 65535, 300);
        put_ranging(1, 0, 1'b0);
        put_ranging(0, 1, 1'b0);
        // Full scale with the old value weighted zero, then fully kept.
        load_settings(1, 2, 3, 65535, 0);
        put_ranging(3, 3, 1'b1);
        load_settings(1, 2, 3, 65535, 256);
        put_ranging(0, 3, 1'b1);

        // Random cycles over a range of settings, the extremes among them.
        run_phase(PRE_LOW_RST, PULSE_RST, TIMEOUT_RST, SCALE_RST, WEIGHT_RST, 350);
        run_phase(0, 0, 5, 65535, 256, 300);
        run_phase(255, 1, 65535, 0, 0, 300);
        run_phase(1, 255, 2, 40000, 511, 300);
        repeat (3)
            run_phase($urandom_range(0, 20), $urandom_range(0, 8), $urandom_range(0, 40),
                      $urandom_range(0, 65535), random_weight(), 220);

        while (got_cnt < queued_cnt) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        while (ranger_words_q.size() != 0) begin
            report_mismatch("missing word", 32'd0, 32'(ranger_words_q.pop_front()));
        end
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a stalled handshake.
    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/uer_pkg.sv
design/uer_tick.sv
design/uer_blend.sv
design/ultrasonic_echo_ranger_unit.sv
bench/tb_ultrasonic_echo_ranger_unit.sv
